FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants for the bitmap block allocator: field widths, request types,
// status codes, config register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int WORD_BITS  = 32;

    localparam int MAX_BLOCKS_DEF = 1024;

    // Request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd2;

    // Configuration reset values
    localparam logic [DATA_W-1:0] POOL_BASE_RST   = 32'd0;
    localparam logic [DATA_W-1:0] POOL_BYTES_RST  = 32'd0;
    localparam logic [DATA_W-1:0] BLOCK_BYTES_RST = 32'd1;

endpackage

FILE: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block allocator with one used bit per block, kept in a RAM.
//
// Usage:
//   Request channel: drive req_type, req_size and release_addr with start high;
//   the item is taken at a rising edge where busy is low. Exactly one result
//   follows: grant_addr and status for one cycle, marked by done. The receiver
//   cannot stall; the result is simply presented once.
//   Configuration: cfg_we, cfg_index, cfg_data write pool_base (0),
//   pool_bytes (1) and block_bytes (2); write only while idle.
// Sequence:
//   A request that fails on a plain compare (too large, null, address below
//   the base, zero block size) is answered from idle. Otherwise a serial
//   divider finds the block count. Allocate then scans the bitmap one 32-bit
//   word at a time, at most ceil(MAX_BLOCKS/32) words, and forms the address
//   (multiply, then add). Free divides again for the block index and does one
//   read-modify-write, or stops there when the index is out of range.
//   One item is in flight at a time; busy stays high until it finishes.
// Reset:
//   The bitmap RAM is cleared one word per cycle, ceil(MAX_BLOCKS/32) words,
//   with busy high. Configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [bba_pkg::DATA_W-1:0]     req_size,
    input  logic [bba_pkg::DATA_W-1:0]     release_addr,
    input  logic                           cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::DATA_W-1:0]     cfg_data,
    output logic                           done,
    output logic [bba_pkg::DATA_W-1:0]     grant_addr,
    output logic [bba_pkg::STATUS_W-1:0]   status
);

    localparam int DW     = bba_pkg::DATA_W;
    localparam int SW     = bba_pkg::STATUS_W;
    localparam int WB     = bba_pkg::WORD_BITS;
    localparam int WORDS  = (MAX_BLOCKS + WB - 1) / WB;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SCAN_W = CNT_W + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIVN  = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;

    // Configuration registers
    logic [DW-1:0] pool_base_reg, pool_bytes_reg, block_bytes_reg;

    // Control
    logic [3:0]       state_reg, state_next;
    logic [WAW-1:0]   word_reg, word_next;
    logic [4:0]       bit_reg, bit_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             type_reg, type_next;
    logic [DW-1:0]    off_reg, off_next;
    logic [DW-1:0]    prod_reg, prod_next;
    logic [DW-1:0]    div_rem_reg, div_rem_next;
    logic [DW-1:0]    div_quo_reg, div_quo_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic             done_reg, done_next;
    logic [DW-1:0]    grant_reg, grant_next;
    logic [SW-1:0]    status_reg, status_next;

    // RAM
    logic           ram_wr_en;
    logic [WAW-1:0] ram_wr_addr;
    logic [WB-1:0]  ram_wr_data;
    logic           ram_rd_en;
    logic [WB-1:0]  ram_rd_data;

    // Divider step
    logic [DW:0]   div_shift;
    logic          div_ge;
    logic [DW:0]   div_rem_step;
    logic [DW-1:0] div_quo_step;

    // Scan
    logic [SCAN_W-1:0] scan_base;
    logic [SCAN_W-1:0] scan_left;
    logic [WB-1:0]     scan_mask;
    logic [WB-1:0]     scan_free;
    logic [4:0]        scan_hit;
    logic [WB-1:0]     hit_onehot;
    logic [WB-1:0]     clr_onehot;

    logic [DW-1:0]    mul_wide;
    logic [CNT_W-1:0] n_sat;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (word_reg),
        .rd_data (ram_rd_data)
    );

    // One restoring division step per cycle, divisor is block_bytes
    always_comb
    begin
        div_shift    = {div_rem_reg, div_quo_reg[DW-1]};
        div_ge       = (div_shift >= {1'b0, block_bytes_reg});
        div_rem_step = div_ge ? (div_shift - {1'b0, block_bytes_reg}) : div_shift;
        div_quo_step = {div_quo_reg[DW-2:0], div_ge};
    end

    assign n_sat = (div_quo_step > DW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                    : div_quo_step[CNT_W-1:0];

    // Bitmap word search: blocks at or beyond the count look used
    always_comb
    begin
        scan_base = SCAN_W'({word_reg, 5'b00000});
        scan_left = SCAN_W'(n_reg) - scan_base;
        for (int b = 0; b < WB; b++)
        begin
            scan_mask[b] = (SCAN_W'(b) >= scan_left);
        end
        scan_free = ~(ram_rd_data | scan_mask);
        scan_hit  = 5'd0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (scan_free[b])
            begin
                scan_hit = 5'(b);
            end
        end
        hit_onehot = WB'(1) << scan_hit;
        clr_onehot = WB'(1) << bit_reg;
    end

    assign mul_wide = DW'(idx_reg) * block_bytes_reg;

    always_comb
    begin
        state_next   = state_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        type_next    = type_reg;
        off_next     = off_reg;
        prod_next    = prod_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        grant_next   = grant_reg;
        status_next  = status_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = word_reg;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (word_reg == WAW'(WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WAW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    type_next    = req_type;
                    off_next     = release_addr - pool_base_reg;
                    grant_next   = '0;
                    div_rem_next = '0;
                    div_quo_next = pool_bytes_reg;
                    div_cnt_next = '0;
                    if (req_type == bba_pkg::REQ_ALLOC)
                    begin
                        if (req_size > block_bytes_reg)
                        begin
                            status_next = bba_pkg::ST_TOO_LARGE;
                            done_next   = 1'b1;
                        end
                        else if (block_bytes_reg == '0)
                        begin
                            status_next = bba_pkg::ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_DIVN;
                        end
                    end
                    else
                    begin
                        if (release_addr == '0)
                        begin
                            status_next = bba_pkg::ST_NULL;
                            done_next   = 1'b1;
                        end
                        else if (release_addr < pool_base_reg || block_bytes_reg == '0)
                        begin
                            status_next = bba_pkg::ST_RANGE;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_DIVN;
                        end
                    end
                end
            end

            S_DIVN:
            begin
                div_rem_next = div_rem_step[DW-1:0];
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    n_next = n_sat;
                    if (type_reg == bba_pkg::REQ_ALLOC)
                    begin
                        if (n_sat == '0)
                        begin
                            status_next = bba_pkg::ST_FULL;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            word_next  = '0;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_quo_next = off_reg;
                        div_cnt_next = '0;
                        state_next   = S_DIVI;
                    end
                end
            end

            S_DIVI:
            begin
                div_rem_next = div_rem_step[DW-1:0];
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    if (div_quo_step >= DW'(n_reg))
                    begin
                        status_next = bba_pkg::ST_RANGE;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        word_next  = WAW'(div_quo_step >> 5);
                        bit_next   = div_quo_step[4:0];
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                if (type_reg == bba_pkg::REQ_FREE)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data & ~clr_onehot;
                    status_next = bba_pkg::ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (|scan_free)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data | hit_onehot;
                    idx_next    = CNT_W'(scan_base + SCAN_W'(scan_hit));
                    state_next  = S_MUL;
                end
                else if ((scan_base + SCAN_W'(WB)) < SCAN_W'(n_reg))
                begin
                    // advance to the next bitmap word
                    word_next  = word_reg + WAW'(1);
                    state_next = S_RD;
                end
                else
                begin
                    status_next = bba_pkg::ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_MUL:
            begin
                prod_next  = mul_wide;
                state_next = S_ADD;
            end

            S_ADD:
            begin
                grant_next  = pool_base_reg + prod_reg;
                status_next = bba_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            word_reg        <= '0;
            div_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            pool_base_reg   <= bba_pkg::POOL_BASE_RST;
            pool_bytes_reg  <= bba_pkg::POOL_BYTES_RST;
            block_bytes_reg <= bba_pkg::BLOCK_BYTES_RST;
        end
        else
        begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bba_pkg::REG_POOL_BASE:   pool_base_reg   <= cfg_data;
                    bba_pkg::REG_POOL_BYTES:  pool_bytes_reg  <= cfg_data;
                    bba_pkg::REG_BLOCK_BYTES: block_bytes_reg <= cfg_data;
                    default:
                    begin
                        // unused index: drop the write
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg     <= bit_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        type_reg    <= type_next;
        off_reg     <= off_next;
        prod_reg    <= prod_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        grant_reg   <= grant_next;
        status_reg  <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign grant_addr = grant_reg;
    assign status     = status_reg;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for bitmap_block_allocator. A behavioral copy of the
// allocator bitmap predicts the grant address and status of every accepted
// request. A monitor compares each done strobe against the oldest prediction.
// Directed cases come first, then random pool setups with allocate/free traffic.
// ----------------------------------------------------------------------------
module tb;

    localparam int DATA_W    = bba_pkg::DATA_W;
    localparam int STATUS_W  = bba_pkg::STATUS_W;
    localparam int CFG_IDX_W = bba_pkg::CFG_IDX_W;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int BLOCK_LIMIT  = bba_pkg::MAX_BLOCKS_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 600000;

    // Index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]   grant;
        logic [STATUS_W-1:0] status;
    } grant_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic [DATA_W-1:0]    req_size;
    logic [DATA_W-1:0]    release_addr;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 done;
    logic [DATA_W-1:0]    grant_addr;
    logic [STATUS_W-1:0]  status;

    // Predicted allocator state
    logic [DATA_W-1:0]      mdl_base;
    logic [DATA_W-1:0]      mdl_pool_bytes;
    logic [DATA_W-1:0]      mdl_block_bytes;
    logic [BLOCK_LIMIT-1:0] used_map;

    grant_result_t     expected_grants[$];
    logic [DATA_W-1:0] live_addrs[$];
    int                fail_count;
    int                cycle_count;
    int                random_sent;
    int                results_seen;
    bit                steady_flow;

    bitmap_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .req_size     (req_size),
        .release_addr (release_addr),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .grant_addr   (grant_addr),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    function automatic logic [DATA_W-1:0] block_total();
        logic [DATA_W-1:0] n;
        if (mdl_block_bytes == '0)
            return '0;
        n = mdl_pool_bytes / mdl_block_bytes;
        if (n > BLOCK_LIMIT)
            n = BLOCK_LIMIT;
        return n;
    endfunction

    function automatic grant_result_t predict_grant(input logic kind,
                                                    input logic [DATA_W-1:0] size,
                                                    input logic [DATA_W-1:0] addr);
        grant_result_t     r;
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] idx;
        bit                found;
        r.grant  = '0;
        r.status = bba_pkg::ST_OK;
        n        = block_total();
        found    = 1'b0;
        if (kind == bba_pkg::REQ_ALLOC)
        begin
            if (size > mdl_block_bytes)
                r.status = bba_pkg::ST_TOO_LARGE;
            else
            begin
                r.status = bba_pkg::ST_FULL;
                // take the lowest free block
                for (idx = 0; idx < n && !found; idx++)
                begin
                    if (!used_map[idx])
                    begin
                        used_map[idx] = 1'b1;
                        r.grant       = mdl_base + idx * mdl_block_bytes;
                        r.status      = bba_pkg::ST_OK;
                        found         = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (addr == '0)
                r.status = bba_pkg::ST_NULL;
            else if (addr < mdl_base || mdl_block_bytes == '0)
                r.status = bba_pkg::ST_RANGE;
            else
            begin
                idx = (addr - mdl_base) / mdl_block_bytes;
                if (idx >= n)
                    r.status = bba_pkg::ST_RANGE;
                else
                    used_map[idx] = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("MISMATCH result %0d %s: expected %h, got %h", results_seen, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        grant_result_t want;
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
                report_mismatch("with no request pending", '0, grant_addr);
            else
            begin
                want = expected_grants.pop_front();
                if (grant_addr !== want.grant)
                    report_mismatch("grant_addr", want.grant, grant_addr);
                if (status !== want.status)
                    report_mismatch("status", DATA_W'(want.status), DATA_W'(status));
            end
            results_seen++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("bitmap_block_allocator test failed");
        $finish;
    end

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic send_request(input logic kind, input logic [DATA_W-1:0] size,
                                input logic [DATA_W-1:0] addr);
        grant_result_t exp_r;
        @(negedge clk);
        start        <= 1'b1;
        req_type     <= kind;
        req_size     <= size;
        release_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        exp_r = predict_grant(kind, size, addr);
        expected_grants.push_back(exp_r);
        if (kind == bba_pkg::REQ_ALLOC && exp_r.status == bba_pkg::ST_OK)
            live_addrs.push_back(exp_r.grant);
        hold_off(pick_gap());
    endtask

    // Hold the request line low until every result is in and the block is idle
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_grants.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        start     <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            bba_pkg::REG_POOL_BASE:   mdl_base        = value;
            bba_pkg::REG_POOL_BYTES:  mdl_pool_bytes  = value;
            bba_pkg::REG_BLOCK_BYTES: mdl_block_bytes = value;
            default:                  ;
        endcase
    endtask

    task automatic configure_pool(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] bytes,
                                  input logic [DATA_W-1:0] block);
        drain_results();
        write_reg(bba_pkg::REG_POOL_BASE, base);
        write_reg(bba_pkg::REG_POOL_BYTES, bytes);
        write_reg(bba_pkg::REG_BLOCK_BYTES, block);
        live_addrs.delete();
    endtask

    task automatic test_after_reset();
        send_request(bba_pkg::REQ_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(bba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(bba_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'd0);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_block_size();
        configure_pool(32'd0, 32'd100, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'd1, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'd0, 32'd0);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'd5);
    endtask

    task automatic test_fill_and_free();
        configure_pool(32'h0000_1000, 32'h0000_00FF, 32'h0000_0040);
        send_request(bba_pkg::REQ_ALLOC, 32'h40, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'h1, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'h0, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'h0, 32'd0);
        // unaligned address frees the block it falls in, twice
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'h0000_1047);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'h0000_1047);
        send_request(bba_pkg::REQ_ALLOC, 32'h20, 32'hDEAD_BEEF);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'h0000_0FFF);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'h0000_10C0);
        send_request(bba_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'h0000_1000);
    endtask

    task automatic test_reconfig_keeps_bits();
        configure_pool(32'h0000_1000, 32'h0000_0040, 32'h0000_0040);
        send_request(bba_pkg::REQ_ALLOC, 32'h0, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'h0, 32'd0);
        // grow the pool: blocks used earlier must still be taken
        configure_pool(32'h0000_1000, 32'hFFFF_FFFF, 32'h0000_0040);
        send_request(bba_pkg::REQ_ALLOC, 32'h0, 32'd0);
    endtask

    task automatic test_address_wrap();
        configure_pool(32'hFFFF_FF00, 32'h0000_0400, 32'h0000_0040);
        write_reg(REG_SPARE, 32'h5A5A_A5A5);
        send_request(bba_pkg::REQ_ALLOC, 32'h40, 32'd0);
        send_request(bba_pkg::REQ_ALLOC, 32'h40, 32'd0);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'h0000_0040);
    endtask

    task automatic test_extreme_block();
        configure_pool(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(bba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(bba_pkg::REQ_FREE, 32'd0, 32'hFFFF_FFFE);
        send_request(bba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic pick_random_pool();
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] bytes;
        logic [DATA_W-1:0] block;
        logic [DATA_W-1:0] count;
        int                r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: block = $urandom_range(1, 8);
            3, 4, 5: block = 32'd1 << $urandom_range(0, 12);
            6, 7:    block = $urandom_range(1, 4096);
            8:       block = $urandom;
            default: block = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        r = $urandom_range(0, 99);
        count = (r < 70) ? $urandom_range(1, 12) : (r < 92) ? $urandom_range(13, 40) : 32'd0;
        if (block == '0 || block > 32'h0000_FFFF)
            bytes = $urandom;
        else
            bytes = count * block + $urandom_range(0, block - 1);
        // saturate the block count now and then
        if ($urandom_range(0, 99) < 8)
        begin
            block = $urandom_range(1, 16);
            bytes = 32'hFFFF_FFFF;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            base = $urandom & 32'hFFFF_F000;
        else if (r < 75)
            base = '0;
        else if (r < 90)
            base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        else
            base = $urandom;
        configure_pool(base, bytes, block);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, $urandom);
    endtask

    task automatic random_request();
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] addr;
        int                r;
        int                k;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                size = $urandom_range(0, mdl_block_bytes);
            else if (k < 85)
                size = mdl_block_bytes;
            else if (mdl_block_bytes == 32'hFFFF_FFFF)
                size = $urandom;
            else
                size = mdl_block_bytes + $urandom_range(1, 32'hFFFF_FFFF - mdl_block_bytes);
            send_request(bba_pkg::REQ_ALLOC, size, $urandom);
        end
        else if (r < 82 && live_addrs.size() > 0)
        begin
            k    = $urandom_range(0, live_addrs.size() - 1);
            addr = live_addrs[k];
            live_addrs.delete(k);
            if (mdl_block_bytes != '0 && $urandom_range(0, 1) != 0)
                addr = addr + $urandom_range(0, mdl_block_bytes - 1);
            send_request(bba_pkg::REQ_FREE, $urandom, addr);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       addr = '0;
                1:       addr = $urandom;
                2:       addr = mdl_base - $urandom_range(1, 64);
                default: addr = mdl_base + block_total() * mdl_block_bytes
                                + $urandom_range(0, 64);
            endcase
            send_request(bba_pkg::REQ_FREE, $urandom, addr);
        end
        random_sent++;
    endtask

    task automatic test_random_pools();
        int n;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick_random_pool();
            steady_flow = ($urandom_range(0, 3) == 0);
            n = $urandom_range(15, 40);
            repeat (n)
                random_request();
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = bba_pkg::REQ_ALLOC;
        req_size        = '0;
        release_addr    = '0;
        cfg_we          = 1'b0;
        cfg_index       = bba_pkg::REG_POOL_BASE;
        cfg_data        = '0;
        mdl_base        = bba_pkg::POOL_BASE_RST;
        mdl_pool_bytes  = bba_pkg::POOL_BYTES_RST;
        mdl_block_bytes = bba_pkg::BLOCK_BYTES_RST;
        used_map        = '0;
        fail_count      = 0;
        random_sent     = 0;
        results_seen    = 0;
        steady_flow     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_zero_block_size();
        test_fill_and_free();
        test_reconfig_keeps_bits();
        test_address_wrap();
        test_extreme_block();
        test_random_pools();

        drain_results();
        hold_off(TAIL_CYCLES);
        if (expected_grants.size() != 0)
            report_mismatch("left without a result", DATA_W'(expected_grants.size()), '0);
        if (fail_count == 0)
            $display("bitmap_block_allocator test passed");
        else
            $display("bitmap_block_allocator test failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bitmap_block_allocator.sv
sim/tb.sv
